/* sv/gmk_pkg.sv */
// gmk_pkg: shared types and constants for the glyph metrics / kerning unit.
// Holds the beat structs, command and status codes, and the divide-by-100 reciprocal.
// No dependencies.
package gmk_pkg;

    // default sizes handed to the top-level parameters
    localparam int GMK_GLYPH_ENTRIES = 256;
    localparam int GMK_KERN_ENTRIES  = 256;
    localparam int GMK_PAGE_LIMIT    = 16;

    // first glyph code held in the metrics store
    localparam logic [15:0] GMK_GLYPH_BASE = 16'h0020;

    // command queue between the front and the back
    localparam int GMK_QUEUE_DEPTH = 2;

    // floor(p / 100) == (p * GMK_DIV100_MULT) >> GMK_DIV100_SHIFT for p < 2^30
    localparam int          GMK_PROD_W       = 26;
    localparam int          GMK_QUOT_W       = 2 * GMK_PROD_W;
    localparam logic [25:0] GMK_DIV100_MULT  = 26'd42949673;
    localparam int          GMK_DIV100_SHIFT = 32;

    localparam int GMK_CFG_IDX_W  = 2;
    localparam int GMK_CFG_DATA_W = 13;

    // configuration register indexes
    localparam logic [GMK_CFG_IDX_W-1:0] GMK_CFG_PAGE_SIZE  = 2'd0;
    localparam logic [GMK_CFG_IDX_W-1:0] GMK_CFG_ROW_HEIGHT = 2'd1;
    localparam logic [GMK_CFG_IDX_W-1:0] GMK_CFG_SPACING    = 2'd2;

    // result status codes
    localparam logic [2:0] GMK_ST_OK         = 3'd0;
    localparam logic [2:0] GMK_ST_MISSING    = 3'd1;
    localparam logic [2:0] GMK_ST_KERN_FULL  = 3'd2;
    localparam logic [2:0] GMK_ST_RANGE      = 3'd3;
    localparam logic [2:0] GMK_ST_ATLAS_FULL = 3'd4;

    typedef enum logic [1:0] {
        GMK_CMD_BEGIN   = 2'd0,
        GMK_CMD_GLYPH   = 2'd1,
        GMK_CMD_KERN    = 2'd2,
        GMK_CMD_MEASURE = 2'd3
    } t_gmk_cmd;

    typedef struct packed {
        t_gmk_cmd            cmd;
        logic [15:0]         code;
        logic [15:0]         other_code;
        logic [7:0]          advance;
        logic [7:0]          render_width;
        logic signed [7:0]   bearing;
        logic signed [15:0]  kern_value;
    } t_gmk_in;

    typedef struct packed {
        logic [18:0] width;
        logic [3:0]  atlas_page;
        logic [11:0] texel_x;
        logic [11:0] texel_y;
        logic [2:0]  status;
    } t_gmk_out;

    // classified command as it sits in the queue
    typedef struct packed {
        t_gmk_in item;
        logic    code_ok;
        logic    other_ok;
    } t_gmk_work;

    typedef struct packed {
        logic [12:0] page_size;
        logic [9:0]  row_height;
        logic [9:0]  spacing_percent;
    } t_gmk_cfg;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_gmk_qstat;

    // back-end status reported to the top
    typedef struct packed {
        logic clearing;
        logic idle;
    } t_gmk_bstat;

endpackage

/* sv/gmk_front.sv */
// gmk_front: accepts command beats and classifies their glyph codes.
// Depends on gmk_pkg.
module gmk_front #(
    parameter int GLYPH_ENTRIES = gmk_pkg::GMK_GLYPH_ENTRIES
) (
    input  logic                i_start,
    input  gmk_pkg::t_gmk_in    i_item,
    input  gmk_pkg::t_gmk_qstat i_qstat,
    input  logic                i_clearing,
    output logic                o_busy,
    output logic                o_push,
    output gmk_pkg::t_gmk_work  o_work
);

    localparam logic [16:0] GLYPH_SPAN = 17'(GLYPH_ENTRIES);

    logic [15:0] code_off;
    logic [15:0] other_off;

    // code maps to a store slot when base <= code < base + entries
    assign code_off  = i_item.code - gmk_pkg::GMK_GLYPH_BASE;
    assign other_off = i_item.other_code - gmk_pkg::GMK_GLYPH_BASE;

    assign o_busy = i_qstat.full || i_clearing;
    assign o_push = i_start && !o_busy;

    always_comb begin
        o_work.item     = i_item;
        o_work.code_ok  = (i_item.code >= gmk_pkg::GMK_GLYPH_BASE)
                          && ({1'b0, code_off} < GLYPH_SPAN);
        o_work.other_ok = (i_item.other_code >= gmk_pkg::GMK_GLYPH_BASE)
                          && ({1'b0, other_off} < GLYPH_SPAN);
    end

endmodule

/* sv/gmk_queue.sv */
// gmk_queue: short command queue between the front and the back.
// Depends on gmk_pkg.
module gmk_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  gmk_pkg::t_gmk_work  i_wdata,
    input  logic                i_pop,
    output gmk_pkg::t_gmk_qstat o_qstat,
    output gmk_pkg::t_gmk_work  o_head
);

    localparam int DEPTH = gmk_pkg::GMK_QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    gmk_pkg::t_gmk_work r_slot [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_wr  = i_push ? ptr_inc(r_wr) : r_wr;
        n_rd  = i_pop  ? ptr_inc(r_rd) : r_rd;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_wdata;
        end
    end

    assign o_head        = r_slot[r_rd];
    assign o_qstat.full  = (r_cnt == CW'(DEPTH));
    assign o_qstat.empty = (r_cnt == '0);

endmodule

/* sv/gmk_back.sv */
// gmk_back: executes queued commands: metrics store, kern table, atlas cursor, measure.
// Depends on gmk_pkg.
module gmk_back #(
    parameter int GLYPH_ENTRIES = gmk_pkg::GMK_GLYPH_ENTRIES,
    parameter int KERN_ENTRIES  = gmk_pkg::GMK_KERN_ENTRIES,
    parameter int PAGE_LIMIT    = gmk_pkg::GMK_PAGE_LIMIT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gmk_pkg::t_gmk_cfg   i_cfg,
    input  gmk_pkg::t_gmk_qstat i_qstat,
    input  gmk_pkg::t_gmk_work  i_head,
    output logic                o_pop,
    output gmk_pkg::t_gmk_bstat o_bstat,
    output logic                o_strobe,
    output gmk_pkg::t_gmk_out   o_result
);

    localparam int GI_W = $clog2(GLYPH_ENTRIES);
    localparam int KI_W = (KERN_ENTRIES > 1) ? $clog2(KERN_ENTRIES) : 1;
    localparam int KC_W = $clog2(KERN_ENTRIES + 1);
    localparam int PG_W = $clog2(PAGE_LIMIT + 1);
    localparam int PO_W = 4;

    typedef struct packed {
        logic               valid;
        logic [7:0]         advance;
        logic signed [7:0]  bearing;
    } t_gmk_metric;

    typedef struct packed {
        logic [15:0]        first;
        logic [15:0]        second;
        logic signed [15:0] adjust;
    } t_gmk_pair;

    typedef enum logic [6:0] {
        S_CLEAR    = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_DISPATCH = 7'b0000100,
        S_SCAN     = 7'b0001000,
        S_MUL1     = 7'b0010000,
        S_MUL2     = 7'b0100000,
        S_EMIT     = 7'b1000000
    } t_state;

    // memories
    t_gmk_metric r_met_mem  [GLYPH_ENTRIES];
    logic        r_mark_mem [GLYPH_ENTRIES];
    t_gmk_pair   r_kern_mem [KERN_ENTRIES];
    t_gmk_metric r_met_rd;
    logic        r_mark_rd;
    t_gmk_pair   r_kern_rd;

    // control
    t_state            r_state, n_state;
    logic [GI_W-1:0]   r_clr_idx, n_clr_idx;
    logic [12:0]       r_cx, n_cx;
    logic [12:0]       r_cy, n_cy;
    logic [PG_W-1:0]   r_page, n_page;
    logic [KC_W-1:0]   r_kcount, n_kcount;
    logic [KC_W-1:0]   r_scan_left, n_scan_left;
    logic              r_pend, n_pend;
    logic              r_strobe, n_strobe;

    // payload
    gmk_pkg::t_gmk_work             r_job, n_job;
    logic signed [17:0]             r_sum, n_sum;
    logic [gmk_pkg::GMK_PROD_W-1:0] r_prod, n_prod;
    logic [gmk_pkg::GMK_QUOT_W-1:0] r_quot, n_quot;
    gmk_pkg::t_gmk_out              r_out, n_out;

    // memory ports
    logic              met_we;
    logic [GI_W-1:0]   met_wa;
    t_gmk_metric       met_wd;
    logic              mark_we;
    logic [GI_W-1:0]   mark_wa;
    logic              mark_wd;
    logic              kern_we;
    logic [KI_W-1:0]   kern_wa;
    t_gmk_pair         kern_wd;
    logic              kern_re;
    logic [KI_W-1:0]   kern_ra;
    logic [15:0]       head_code_off;
    logic [15:0]       head_other_off;
    logic [15:0]       job_code_off;
    logic [GI_W-1:0]   job_slot;
    logic [KC_W-1:0]   scan_m1;

    // placement
    logic [13:0]       x_end;
    logic [13:0]       y_step;
    logic [14:0]       y_chk;
    logic              wrap_x;
    logic              wrap_y;
    logic [12:0]       pl_x;
    logic [12:0]       pl_y;
    logic [PG_W-1:0]   pl_page;
    logic              hit;

    assign head_code_off  = i_head.item.code - gmk_pkg::GMK_GLYPH_BASE;
    assign head_other_off = i_head.item.other_code - gmk_pkg::GMK_GLYPH_BASE;
    assign job_code_off   = r_job.item.code - gmk_pkg::GMK_GLYPH_BASE;
    assign job_slot       = job_code_off[GI_W-1:0];
    assign scan_m1        = r_scan_left - 1'b1;

    // shelf placement: wrap to next row on x overflow, next page on y overflow
    assign x_end   = {1'b0, r_cx} + 14'(r_job.item.render_width);
    assign y_step  = {1'b0, r_cy} + 14'(i_cfg.row_height);
    assign y_chk   = {1'b0, y_step} + 15'(i_cfg.row_height);
    assign wrap_x  = x_end > {1'b0, i_cfg.page_size};
    assign wrap_y  = wrap_x && (y_chk > {2'b00, i_cfg.page_size});
    assign pl_x    = wrap_x ? '0 : r_cx;
    assign pl_y    = wrap_x ? (wrap_y ? '0 : y_step[12:0]) : r_cy;
    assign pl_page = r_page + PG_W'(wrap_y);

    assign hit = r_pend && (r_kern_rd.first == r_job.item.other_code)
                 && (r_kern_rd.second == r_job.item.code);

    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_page      = r_page;
        n_kcount    = r_kcount;
        n_scan_left = r_scan_left;
        n_pend      = 1'b0;
        n_strobe    = 1'b0;
        n_job       = r_job;
        n_sum       = r_sum;
        n_prod      = r_prod;
        n_quot      = r_quot;
        n_out       = r_out;
        o_pop       = 1'b0;
        met_we      = 1'b0;
        met_wa      = job_slot;
        met_wd      = '{valid: 1'b1, advance: r_job.item.advance,
                        bearing: r_job.item.bearing};
        mark_we     = 1'b0;
        mark_wa     = job_slot;
        mark_wd     = 1'b0;
        kern_we     = 1'b0;
        kern_wa     = r_kcount[KI_W-1:0];
        kern_wd     = '{first: r_job.item.code, second: r_job.item.other_code,
                        adjust: r_job.item.kern_value};
        kern_re     = 1'b0;
        kern_ra     = scan_m1[KI_W-1:0];

        case (r_state)
            S_CLEAR: begin
                met_we  = 1'b1;
                met_wa  = r_clr_idx;
                met_wd  = '0;
                mark_we = 1'b1;
                mark_wa = r_clr_idx;
                if (r_clr_idx == GI_W'(GLYPH_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop   = 1'b1;
                    n_job   = i_head;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_out    = '0;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
                case (r_job.item.cmd)
                    gmk_pkg::GMK_CMD_BEGIN: begin
                        n_cx     = '0;
                        n_cy     = '0;
                        n_page   = '0;
                        n_kcount = '0;
                    end
                    gmk_pkg::GMK_CMD_GLYPH: begin
                        if (!r_job.code_ok) begin
                            n_out.status = gmk_pkg::GMK_ST_RANGE;
                        end else begin
                            met_we  = 1'b1;
                            mark_we = 1'b1;
                            if (r_page >= PG_W'(PAGE_LIMIT)) begin
                                n_out.status = gmk_pkg::GMK_ST_ATLAS_FULL;
                            end else if (pl_page >= PG_W'(PAGE_LIMIT)) begin
                                n_out.status = gmk_pkg::GMK_ST_ATLAS_FULL;
                                n_page       = PG_W'(PAGE_LIMIT);
                                n_cx         = '0;
                                n_cy         = '0;
                            end else begin
                                n_out.atlas_page = PO_W'(pl_page);
                                n_out.texel_x    = pl_x[11:0];
                                n_out.texel_y    = pl_y[11:0];
                                n_page           = pl_page;
                                n_cy             = pl_y;
                                n_cx             = wrap_x ? 13'(r_job.item.render_width)
                                                          : x_end[12:0];
                            end
                        end
                    end
                    gmk_pkg::GMK_CMD_KERN: begin
                        if (!r_job.code_ok) begin
                            n_out.status = gmk_pkg::GMK_ST_RANGE;
                        end else if (r_kcount >= KC_W'(KERN_ENTRIES)) begin
                            n_out.status = gmk_pkg::GMK_ST_KERN_FULL;
                        end else begin
                            kern_we  = 1'b1;
                            mark_we  = 1'b1;
                            mark_wd  = 1'b1;
                            n_kcount = r_kcount + 1'b1;
                        end
                    end
                    gmk_pkg::GMK_CMD_MEASURE: begin
                        if (!r_job.code_ok) begin
                            n_out.status = gmk_pkg::GMK_ST_RANGE;
                        end else if (!r_met_rd.valid) begin
                            n_out.status = gmk_pkg::GMK_ST_MISSING;
                        end else begin
                            n_strobe = 1'b0;
                            n_sum    = $signed({10'b0, r_met_rd.advance})
                                       + $signed({{10{r_met_rd.bearing[7]}},
                                                  r_met_rd.bearing});
                            if (r_job.other_ok && r_mark_rd) begin
                                n_scan_left = r_kcount;
                                n_state     = S_SCAN;
                            end else begin
                                n_state = S_MUL1;
                            end
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                // newest pair first; one table read issued per cycle
                if (hit) begin
                    n_sum   = r_sum + $signed({{2{r_kern_rd.adjust[15]}},
                                               r_kern_rd.adjust});
                    n_state = S_MUL1;
                end else if (r_scan_left != '0) begin
                    kern_re     = 1'b1;
                    n_pend      = 1'b1;
                    n_scan_left = scan_m1;
                end else begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                if (!r_sum[17] && (r_sum != '0)) begin
                    n_prod = gmk_pkg::GMK_PROD_W'(r_sum[15:0])
                             * gmk_pkg::GMK_PROD_W'(i_cfg.spacing_percent);
                end else begin
                    n_prod = '0;
                end
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_quot  = gmk_pkg::GMK_QUOT_W'(r_prod)
                          * gmk_pkg::GMK_QUOT_W'(gmk_pkg::GMK_DIV100_MULT);
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_out        = '0;
                n_out.width  = r_quot[gmk_pkg::GMK_DIV100_SHIFT +: 19];
                n_out.status = gmk_pkg::GMK_ST_OK;
                n_strobe     = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_page      <= '0;
            r_kcount    <= '0;
            r_scan_left <= '0;
            r_pend      <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_page      <= n_page;
            r_kcount    <= n_kcount;
            r_scan_left <= n_scan_left;
            r_pend      <= n_pend;
            r_strobe    <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_sum  <= n_sum;
        r_prod <= n_prod;
        r_quot <= n_quot;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (met_we) begin
            r_met_mem[met_wa] <= met_wd;
        end
        if (o_pop) begin
            r_met_rd <= r_met_mem[head_code_off[GI_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            r_mark_mem[mark_wa] <= mark_wd;
        end
        if (o_pop) begin
            r_mark_rd <= r_mark_mem[head_other_off[GI_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (kern_we) begin
            r_kern_mem[kern_wa] <= kern_wd;
        end
        if (kern_re) begin
            r_kern_rd <= r_kern_mem[kern_ra];
        end
    end

    assign o_bstat.clearing = (r_state == S_CLEAR);
    assign o_bstat.idle     = (r_state == S_IDLE);
    assign o_strobe         = r_strobe;
    assign o_result         = r_out;

endmodule

/* sv/glyph_metrics_kerning_unit_core.sv */
// glyph_metrics_kerning_unit_core: top level of the glyph metrics / kerning unit.
// Depends on gmk_pkg, gmk_front, gmk_queue, gmk_back.
// Usage
//   Command channel: drive i_item and raise start; the beat is taken at a rising
//   edge where start is high and busy is low. Every command (begin font, write
//   glyph, write kern pair, measure) gives exactly one result beat.
//   Result channel: o_result is valid for the single cycle o_strobe is high; there
//   is no back-pressure, so every beat must be taken as it comes.
//   Config port: i_cfg_we/i_cfg_idx/i_cfg_data write page_size, row_height and
//   spacing_percent, one per write; write them only while no command is open.
// Timing
//   A two-beat queue parts the decode front from the execute back; busy rises when
//   both slots are taken. Begin, glyph and kern results are registered in
//   DISPATCH after the back pops them; a measure with a stored glyph goes on
//   through MUL1, MUL2 and EMIT. When the previous character has pairs, the back
//   walks the kern table before MUL1, newest first, one read per cycle, until a
//   match or the end. Pops happen only in IDLE; results leave in command order.
// Reset
//   After i_rst_n the back clears the metrics store, one entry per cycle,
//   with busy high; config writes are taken then.
module glyph_metrics_kerning_unit_core #(
    parameter int GLYPH_ENTRIES = gmk_pkg::GMK_GLYPH_ENTRIES,
    parameter int KERN_ENTRIES  = gmk_pkg::GMK_KERN_ENTRIES,
    parameter int PAGE_LIMIT    = gmk_pkg::GMK_PAGE_LIMIT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  gmk_pkg::t_gmk_in                    i_item,
    output logic                                busy,
    output logic                                o_strobe,
    output gmk_pkg::t_gmk_out                   o_result,
    input  logic                                i_cfg_we,
    input  logic [gmk_pkg::GMK_CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gmk_pkg::GMK_CFG_DATA_W-1:0]  i_cfg_data
);

    gmk_pkg::t_gmk_cfg   r_cfg, n_cfg;
    gmk_pkg::t_gmk_qstat qstat;
    gmk_pkg::t_gmk_bstat bstat;
    gmk_pkg::t_gmk_work  push_work;
    gmk_pkg::t_gmk_work  head_work;
    logic                push;
    logic                pop;

    // configuration registers; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                gmk_pkg::GMK_CFG_PAGE_SIZE:  n_cfg.page_size       = i_cfg_data;
                gmk_pkg::GMK_CFG_ROW_HEIGHT: n_cfg.row_height      = i_cfg_data[9:0];
                gmk_pkg::GMK_CFG_SPACING:    n_cfg.spacing_percent = i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.page_size       <= 13'd256;
            r_cfg.row_height      <= 10'd16;
            r_cfg.spacing_percent <= 10'd100;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // front: take and classify the beat
    gmk_front #(
        .GLYPH_ENTRIES (GLYPH_ENTRIES)
    ) u_front (
        .i_start    (start),
        .i_item     (i_item),
        .i_qstat    (qstat),
        .i_clearing (bstat.clearing),
        .o_busy     (busy),
        .o_push     (push),
        .o_work     (push_work)
    );

    gmk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_work),
        .i_pop   (pop),
        .o_qstat (qstat),
        .o_head  (head_work)
    );

    // back: stores, cursor, kern scan and scaling
    gmk_back #(
        .GLYPH_ENTRIES (GLYPH_ENTRIES),
        .KERN_ENTRIES  (KERN_ENTRIES),
        .PAGE_LIMIT    (PAGE_LIMIT)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_qstat  (qstat),
        .i_head   (head_work),
        .o_pop    (pop),
        .o_bstat  (bstat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // no result beat can come out of the store sweep
    a_no_beat_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bstat.clearing |-> !o_strobe)
        else $error("result beat during metrics store sweep");

    // queue never overflows or underflows
    a_queue_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && qstat.full && !pop) && !(pop && qstat.empty))
        else $error("command queue overflow or underflow");

    // reset always starts the sweep, so no command is taken right after it
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("block accepting commands right after reset");

    // an atlas-full result carries no placement
    a_full_no_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == gmk_pkg::GMK_ST_ATLAS_FULL)
        |-> (o_result.atlas_page == '0 && o_result.texel_x == '0
             && o_result.texel_y == '0 && o_result.width == '0))
        else $error("atlas-full result with placement");

    // an idle back always takes a waiting command
    a_idle_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (bstat.idle && !qstat.empty) |-> pop)
        else $error("back idle with a command waiting");

endmodule

/* dv/glyph_metrics_kerning_unit_core_test.sv */
// Self-checking test of glyph_metrics_kerning_unit_core: glyph store, kern table and atlas
// cursor are tracked in a local predictor and every result beat is checked in order.
// Depends on gmk_pkg and the RTL of the core only.
`timescale 1ns / 1ps

module glyph_metrics_kerning_unit_core_test;
    import gmk_pkg::*;

    localparam int GLYPH_N     = GMK_GLYPH_ENTRIES;
    localparam int KERN_N      = GMK_KERN_ENTRIES;
    localparam int PAGES       = GMK_PAGE_LIMIT;
    localparam int STALL_LIMIT = 20000;  // cycles without any beat before giving up
    localparam int TAIL_CYCLES = 300;    // covers the longest measure (full kern scan)

    // ---------------------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ---------------------------------------------------------------------------------
    logic                      i_clk;
    logic                      i_rst_n    = 1'b0;
    logic                      start      = 1'b0;
    t_gmk_in                   i_item     = '0;
    logic                      busy;
    logic                      o_strobe;
    t_gmk_out                  o_result;
    logic                      i_cfg_we   = 1'b0;
    logic [GMK_CFG_IDX_W-1:0]  i_cfg_idx  = GMK_CFG_PAGE_SIZE;
    logic [GMK_CFG_DATA_W-1:0] i_cfg_data = '0;

    glyph_metrics_kerning_unit_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_item     (i_item),
        .busy       (busy),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------------------
    // Predictor state: a private copy of the metrics store, pair list, cursor and regs
    // ---------------------------------------------------------------------------------
    typedef struct {
        bit                 present;
        bit                 has_pairs;
        logic [7:0]         adv;
        logic signed [7:0]  bear;
    } t_glyph_entry;

    t_glyph_entry       glyphs [GLYPH_N];
    logic [15:0]        pair_first [KERN_N];
    logic [15:0]        pair_second [KERN_N];
    logic signed [15:0] pair_adjust [KERN_N];
    int unsigned        pair_count;
    int unsigned        cur_x, cur_y, cur_page;
    int unsigned        page_edge, row_pitch, spacing_pct;

    t_gmk_out owed_results [$];   // results still to come, oldest first
    int       fault_count = 0;
    int       quiet_cycles = 0;
    bit       gaps_on = 1'b1;

    // code -> store slot; out-of-range codes have no slot
    function automatic bit glyph_slot(input logic [15:0] code, output int unsigned slot);
        slot = 0;
        if (int'(code) < int'(GMK_GLYPH_BASE) ||
            int'(code) - int'(GMK_GLYPH_BASE) >= GLYPH_N)
            return 1'b0;
        slot = int'(code) - int'(GMK_GLYPH_BASE);
        return 1'b1;
    endfunction

    // Applies one command to the predictor and returns the result beat it must produce.
    function automatic t_gmk_out font_cmd_result(input t_gmk_in beat);
        t_gmk_out    res;
        int unsigned slot, prev_slot, rw, idx;
        longint      total, scaled;
        res = '0;
        rw  = int'(beat.render_width);
        case (beat.cmd)
            GMK_CMD_BEGIN: begin
                cur_x      = 0;
                cur_y      = 0;
                cur_page   = 0;
                pair_count = 0;
            end
            GMK_CMD_GLYPH: begin
                if (!glyph_slot(beat.code, slot)) begin
                    res.status = GMK_ST_RANGE;
                end else begin
                    // metrics land even when the atlas is already full
                    glyphs[slot].present   = 1'b1;
                    glyphs[slot].has_pairs = 1'b0;
                    glyphs[slot].adv       = beat.advance;
                    glyphs[slot].bear      = beat.bearing;
                    if (cur_page >= PAGES) begin
                        res.status = GMK_ST_ATLAS_FULL;
                    end else begin
                        // row overflow opens a new shelf; shelf overflow opens a new page
                        if (cur_x + rw > page_edge) begin
                            cur_x = 0;
                            cur_y = cur_y + row_pitch;
                            if (cur_y + row_pitch > page_edge) begin
                                cur_y    = 0;
                                cur_page = cur_page + 1;
                            end
                        end
                        if (cur_page >= PAGES) begin
                            cur_page   = PAGES;
                            cur_x      = 0;
                            cur_y      = 0;
                            res.status = GMK_ST_ATLAS_FULL;
                        end else begin
                            res.atlas_page = 4'(cur_page);
                            res.texel_x    = 12'(cur_x);
                            res.texel_y    = 12'(cur_y);
                            cur_x          = cur_x + rw;
                        end
                    end
                end
            end
            GMK_CMD_KERN: begin
                if (!glyph_slot(beat.code, slot)) begin
                    res.status = GMK_ST_RANGE;
                end else if (pair_count >= KERN_N) begin
                    res.status = GMK_ST_KERN_FULL;
                end else begin
                    pair_first[pair_count]  = beat.code;
                    pair_second[pair_count] = beat.other_code;
                    pair_adjust[pair_count] = beat.kern_value;
                    pair_count              = pair_count + 1;
                    glyphs[slot].has_pairs  = 1'b1;   // set even for an absent glyph
                end
            end
            default: begin  // measure
                if (!glyph_slot(beat.code, slot)) begin
                    res.status = GMK_ST_RANGE;
                end else if (!glyphs[slot].present) begin
                    res.status = GMK_ST_MISSING;
                end else begin
                    total = longint'(glyphs[slot].adv) + longint'(glyphs[slot].bear);
                    if (beat.other_code != 16'd0 && glyph_slot(beat.other_code, prev_slot)
                        && glyphs[prev_slot].has_pairs) begin
                        // newest matching pair wins
                        idx = pair_count;
                        while (idx > 0) begin
                            idx = idx - 1;
                            if (pair_first[idx] == beat.other_code &&
                                pair_second[idx] == beat.code) begin
                                total = total + longint'(pair_adjust[idx]);
                                break;
                            end
                        end
                    end
                    if (total > 0) begin
                        scaled    = (total * longint'(spacing_pct)) / 100;
                        res.width = 19'(scaled);
                    end
                end
            end
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------------------------
    // Result checking: every strobe beat against the oldest owed result
    // ---------------------------------------------------------------------------------
    task automatic log_fault(input string what, input t_gmk_out want, input t_gmk_out got);
        string exp_txt;
        string got_txt;
        fault_count++;
        if (fault_count <= 10) begin
            exp_txt = $sformatf("exp w=%0d pg=%0d x=%0d y=%0d st=%0d", want.width,
                                want.atlas_page, want.texel_x, want.texel_y, want.status);
            got_txt = $sformatf("got w=%0d pg=%0d x=%0d y=%0d st=%0d", got.width,
                                got.atlas_page, got.texel_x, got.texel_y, got.status);
            $display("MISMATCH %s @%0t: %s | %s", what, $time, exp_txt, got_txt);
        end
    endtask

    always @(posedge i_clk) begin
        t_gmk_out want;
        if (i_rst_n && o_strobe) begin
            if (owed_results.size() == 0) begin
                log_fault("unexpected beat", '0, o_result);
            end else begin
                want = owed_results.pop_front();
                if (o_result.width !== want.width || o_result.atlas_page !== want.atlas_page ||
                    o_result.texel_x !== want.texel_x || o_result.texel_y !== want.texel_y ||
                    o_result.status !== want.status)
                    log_fault("field", want, o_result);
            end
        end
    end

    // Watchdog: any accepted command or result beat counts as progress.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------------------
    // mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic t_gmk_in beat_of(input t_gmk_cmd cmd, input logic [15:0] code,
                                        input logic [15:0] other, input logic [7:0] adv,
                                        input logic [7:0] rw, input logic signed [7:0] bear,
                                        input logic signed [15:0] kv);
        t_gmk_in b;
        b.cmd          = cmd;
        b.code         = code;
        b.other_code   = other;
        b.advance      = adv;
        b.render_width = rw;
        b.bearing      = bear;
        b.kern_value   = kv;
        return b;
    endfunction

    // Drives one command at a falling edge and holds it until the core takes it.
    task automatic send_beat(input t_gmk_in beat);
        int unsigned gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= beat;
        do @(posedge i_clk); while (busy);
        owed_results.push_back(font_cmd_result(beat));
    endtask

    // Drops start and waits until every owed result has come back.
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes all three registers back to back while the core is idle.
    task automatic load_config(input int unsigned edge_len, input int unsigned pitch,
                               input int unsigned pct);
        settle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= GMK_CFG_PAGE_SIZE;
        i_cfg_data <= GMK_CFG_DATA_W'(edge_len);
        @(negedge i_clk);
        i_cfg_idx  <= GMK_CFG_ROW_HEIGHT;
        i_cfg_data <= GMK_CFG_DATA_W'(pitch);
        @(negedge i_clk);
        i_cfg_idx  <= GMK_CFG_SPACING;
        i_cfg_data <= GMK_CFG_DATA_W'(pct);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        page_edge   = edge_len & 32'h1FFF;
        row_pitch   = pitch & 32'h3FF;
        spacing_pct = pct & 32'h3FF;
    endtask

    // Code picker: mostly a small hot set so glyphs, pairs and measures meet.
    function automatic logic [15:0] pick_code();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return GMK_GLYPH_BASE + 16'($urandom_range(0, 23));
        if (r < 85) return GMK_GLYPH_BASE + 16'($urandom_range(0, GLYPH_N - 1));
        if (r < 90) return GMK_GLYPH_BASE - 16'($urandom_range(1, 32));
        return 16'($urandom);
    endfunction

    function automatic t_gmk_in random_beat();
        t_gmk_in     b;
        int unsigned r;
        r              = $urandom_range(0, 99);
        b.cmd          = (r < 3)  ? GMK_CMD_BEGIN :
                         (r < 38) ? GMK_CMD_GLYPH :
                         (r < 62) ? GMK_CMD_KERN  : GMK_CMD_MEASURE;
        b.code         = pick_code();
        b.other_code   = pick_code();
        b.advance      = 8'($urandom);
        b.render_width = $urandom_range(0, 1) ? 8'($urandom_range(0, 31)) : 8'($urandom);
        b.bearing      = 8'($urandom);
        b.kern_value   = $urandom_range(0, 1) ? 16'($urandom_range(0, 200) - 100)
                                              : 16'($urandom);
        if (b.cmd == GMK_CMD_MEASURE && $urandom_range(0, 4) == 0)
            b.other_code = 16'd0;
        // noise: anything at all
        if ($urandom_range(0, 9) == 0) begin
            b.cmd        = t_gmk_cmd'(2'($urandom));
            b.code       = 16'($urandom);
            b.other_code = 16'($urandom);
        end
        return b;
    endfunction

    // ---------------------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------------------
    // Field extremes, every command and the corner cases at reset register values.
    task automatic test_directed();
        send_beat(beat_of(GMK_CMD_BEGIN,   16'h0000, 16'h0000, 8'd0,   8'd0,   8'sd0, 16'sd0));
        send_beat(beat_of(GMK_CMD_GLYPH,   16'h0041, 16'h0000, 8'd10,  8'd12,  8'sd2, 16'sd0));
        // widest glyph overflows the row
        send_beat(beat_of(GMK_CMD_GLYPH,   16'h0020, 16'hFFFF, 8'd255, 8'd255, 8'sd127,
                          16'sd0));
        send_beat(beat_of(GMK_CMD_GLYPH,   16'h011F, 16'h0000, 8'd0,   8'd0,   8'sh80,
                          16'sd0));
        // codes just outside the store on both ends, and the top code
        send_beat(beat_of(GMK_CMD_GLYPH,   16'h001F, 16'h0000, 8'd5,   8'd5,   8'sd0, 16'sd0));
        send_beat(beat_of(GMK_CMD_GLYPH,   16'h0120, 16'h0000, 8'd5,   8'd5,   8'sd0, 16'sd0));
        send_beat(beat_of(GMK_CMD_GLYPH,   16'hFFFF, 16'hFFFF, 8'd255, 8'd255, -8'sd1,
                          -16'sd1));
        send_beat(beat_of(GMK_CMD_KERN,    16'h0041, 16'h0020, 8'd0,   8'd0,   8'sd0,
                          16'sd32767));
        // later pair for the same characters must win
        send_beat(beat_of(GMK_CMD_KERN,    16'h0041, 16'h0020, 8'd0,   8'd0,   8'sd0,
                          16'sh8000));
        send_beat(beat_of(GMK_CMD_KERN,    16'h001F, 16'h0041, 8'd0,   8'd0,   8'sd0, 16'sd9));
        // pair whose first glyph was never written
        send_beat(beat_of(GMK_CMD_KERN,    16'h0050, 16'h0041, 8'd0,   8'd0,   8'sd0, 16'sd5));
        // negative total saturates to zero
        send_beat(beat_of(GMK_CMD_MEASURE, 16'h0020, 16'h0041, 8'd0,   8'd0,   8'sd0, 16'sd0));
        send_beat(beat_of(GMK_CMD_MEASURE, 16'h0020, 16'h0000, 8'd0,   8'd0,   8'sd0, 16'sd0));
        send_beat(beat_of(GMK_CMD_MEASURE, 16'h011F, 16'h0120, 8'd0,   8'd0,   8'sd0, 16'sd0));
        send_beat(beat_of(GMK_CMD_MEASURE, 16'h0050, 16'h0000, 8'd0,   8'd0,   8'sd0, 16'sd0));
        send_beat(beat_of(GMK_CMD_MEASURE, 16'h0000, 16'h0041, 8'd0,   8'd0,   8'sd0, 16'sd0));
        send_beat(beat_of(GMK_CMD_MEASURE, 16'h0041, 16'h0050, 8'd0,   8'd0,   8'sd0, 16'sd0));
        // rewrite drops the glyph's pair mark
        send_beat(beat_of(GMK_CMD_GLYPH,   16'h0041, 16'h0000, 8'd20,  8'd3,   -8'sd4,
                          16'sd0));
        send_beat(beat_of(GMK_CMD_MEASURE, 16'h0020, 16'h0041, 8'd0,   8'd0,   8'sd0, 16'sd0));
        send_beat(beat_of(GMK_CMD_MEASURE, 16'h0020, 16'h0042, 8'd0,   8'd0,   8'sd0, 16'sd0));
        send_beat(beat_of(GMK_CMD_KERN,    16'h0041, 16'hFFFF, 8'd0,   8'd0,   8'sd0,
                          16'sd100));
        send_beat(beat_of(GMK_CMD_MEASURE, 16'h0041, 16'h0041, 8'd0,   8'd0,   8'sd0, 16'sd0));
        // begin keeps the store but empties the pair list
        send_beat(beat_of(GMK_CMD_BEGIN,   16'hFFFF, 16'hFFFF, 8'd255, 8'd255, -8'sd1,
                          -16'sd1));
        send_beat(beat_of(GMK_CMD_MEASURE, 16'h0020, 16'h0041, 8'd0,   8'd0,   8'sd0, 16'sd0));
        send_beat(beat_of(GMK_CMD_GLYPH,   16'h0030, 16'h0000, 8'd7,   8'd9,   8'sd1, 16'sd0));
    endtask

    // Register extremes: one glyph per page until the atlas runs out, then huge pages.
    task automatic test_atlas_limits();
        load_config(1, 1023, 1000);
        send_beat(beat_of(GMK_CMD_BEGIN, 16'h0000, 16'h0000, 8'd0, 8'd0, 8'sd0, 16'sd0));
        for (int i = 0; i < PAGES + 2; i++)
            send_beat(beat_of(GMK_CMD_GLYPH, 16'h0021 + 16'(i), 16'h0000, 8'(i + 1), 8'd1,
                              8'sd3, 16'sd0));
        // still full even for a zero-width glyph
        send_beat(beat_of(GMK_CMD_GLYPH,   16'h0040, 16'h0000, 8'd255, 8'd0, 8'sd127, 16'sd0));
        send_beat(beat_of(GMK_CMD_MEASURE, 16'h0040, 16'h0000, 8'd0,   8'd0, 8'sd0, 16'sd0));
        send_beat(beat_of(GMK_CMD_BEGIN,   16'h0000, 16'h0000, 8'd0,   8'd0, 8'sd0, 16'sd0));
        send_beat(beat_of(GMK_CMD_GLYPH,   16'h0022, 16'h0000, 8'd4,   8'd1, 8'sd0, 16'sd0));

        load_config(4096, 1, 0);
        send_beat(beat_of(GMK_CMD_BEGIN, 16'h0000, 16'h0000, 8'd0, 8'd0, 8'sd0, 16'sd0));
        for (int i = 0; i < 18; i++)
            send_beat(beat_of(GMK_CMD_GLYPH, 16'h0060 + 16'(i), 16'h0000, 8'd90, 8'd255,
                              8'sd0, 16'sd0));
        send_beat(beat_of(GMK_CMD_MEASURE, 16'h0060, 16'h0000, 8'd0, 8'd0, 8'sd0, 16'sd0));
    endtask

    // Fills the pair list past its end, then measures that hit an old pair, a new one or none.
    task automatic test_kern_table_full();
        load_config(256, 16, 100);
        send_beat(beat_of(GMK_CMD_BEGIN, 16'h0000, 16'h0000, 8'd0, 8'd0, 8'sd0, 16'sd0));
        for (int i = 0; i < 8; i++)
            send_beat(beat_of(GMK_CMD_GLYPH, 16'h0021 + 16'(i), 16'h0000, 8'($urandom),
                              8'd8, 8'($urandom), 16'sd0));
        for (int i = 0; i < KERN_N + 2; i++)
            send_beat(beat_of(GMK_CMD_KERN, 16'h0021,
                              (i == 7) ? 16'h0022 : 16'h0023 + 16'(i % 5),
                              8'd0, 8'd0, 8'sd0, 16'($urandom_range(0, 200) - 100)));
        send_beat(beat_of(GMK_CMD_MEASURE, 16'h0022, 16'h0021, 8'd0, 8'd0, 8'sd0, 16'sd0));
        send_beat(beat_of(GMK_CMD_MEASURE, 16'h0024, 16'h0021, 8'd0, 8'd0, 8'sd0, 16'sd0));
        send_beat(beat_of(GMK_CMD_MEASURE, 16'h0028, 16'h0021, 8'd0, 8'd0, 8'sd0, 16'sd0));
        send_beat(beat_of(GMK_CMD_MEASURE, 16'h0021, 16'h0022, 8'd0, 8'd0, 8'sd0, 16'sd0));
        send_beat(beat_of(GMK_CMD_BEGIN,   16'h0000, 16'h0000, 8'd0, 8'd0, 8'sd0, 16'sd0));
        send_beat(beat_of(GMK_CMD_KERN,    16'h0021, 16'h0022, 8'd0, 8'd0, 8'sd0, 16'sd3));
        send_beat(beat_of(GMK_CMD_MEASURE, 16'h0022, 16'h0021, 8'd0, 8'd0, 8'sd0, 16'sd0));
    endtask

    // Random font sessions under a spread of register settings.
    task automatic test_random_mix();
        int unsigned edges [5] = '{256, 40, 4096, 1, 300};
        int unsigned pitches [5] = '{16, 7, 1023, 1, 20};
        int unsigned pcts [5] = '{100, 37, 1000, 0, 150};
        for (int p = 0; p < 8; p++) begin
            if (p < 5)
                load_config(edges[p], pitches[p], pcts[p]);
            else
                load_config($urandom_range(1, 4096), $urandom_range(1, 1023),
                            $urandom_range(0, 1000));
            gaps_on = (p % 3 != 1);   // every third phase runs back to back
            if (p % 4 != 3)
                send_beat(beat_of(GMK_CMD_BEGIN, 16'h0000, 16'h0000, 8'd0, 8'd0, 8'sd0,
                                  16'sd0));
            for (int i = 0; i < 57; i++)
                send_beat(random_beat());
        end
        gaps_on = 1'b1;
    endtask

    // ---------------------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < GLYPH_N; i++)
            glyphs[i] = '{1'b0, 1'b0, 8'd0, 8'sd0};
        pair_count  = 0;
        cur_x       = 0;
        cur_y       = 0;
        cur_page    = 0;
        page_edge   = 256;
        row_pitch   = 16;
        spacing_pct = 100;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_atlas_limits();
        test_kern_table_full();
        test_random_mix();

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && owed_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
sv/gmk_pkg.sv
sv/gmk_front.sv
sv/gmk_queue.sv
sv/gmk_back.sv
sv/glyph_metrics_kerning_unit_core.sv
dv/glyph_metrics_kerning_unit_core_test.sv
